// ===== rtl/core/psm_pkg.sv =====
// Shared types and constants for the PSG / direct-sound stereo mixer.
`default_nettype none

package psm_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEVEL_W    = 9;
  localparam int unsigned CLAMP_W    = 10;
  localparam int unsigned FILT_W     = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // Mix clamp ceiling and DC-blocker pole (65360 / 65536)
  localparam logic [CLAMP_W-1:0] PSM_CLAMP_MAX = 10'h3FF;
  localparam logic [16:0]        PSM_CAP_COEF  = 17'd65360;
  localparam logic [8:0]         PSM_BIAS_RST  = 9'h100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_EN_L  = 3'd0,
    REG_TONE_EN_R  = 3'd1,
    REG_TONE_VOL_L = 3'd2,
    REG_TONE_VOL_R = 3'd3,
    REG_TONE_ATTEN = 3'd4,
    REG_FIFO_ROUTE = 3'd5,
    REG_BIAS       = 3'd6,
    REG_RES_MODE   = 3'd7
  } psm_reg_e;

  // Tone attenuation codes
  typedef enum logic [1:0] {
    ATTEN_QUARTER = 2'd0,
    ATTEN_HALF    = 2'd1,
    ATTEN_FULL    = 2'd2,
    ATTEN_NONE    = 2'd3
  } psm_atten_e;

  // Register file contents
  typedef struct packed {
    logic [3:0] tone_en_l;
    logic [3:0] tone_en_r;
    logic [2:0] tone_vol_l;
    logic [2:0] tone_vol_r;
    psm_atten_e tone_atten;
    logic [3:0] fifo_route;
    logic [8:0] bias;
    logic [1:0] res_mode;
  } psm_cfg_t;

  localparam psm_cfg_t PSM_CFG_RESET = '{
    tone_en_l:  4'h0,
    tone_en_r:  4'h0,
    tone_vol_l: 3'h0,
    tone_vol_r: 3'h0,
    tone_atten: ATTEN_QUARTER,
    fifo_route: 4'h0,
    bias:       PSM_BIAS_RST,
    res_mode:   2'h0
  };

  // Per-side mixing controls
  typedef struct packed {
    logic [3:0] tone_en;
    logic [2:0] tone_vol;
    logic       use_a;
    logic       use_b;
    psm_atten_e atten;
    logic [8:0] bias;
    logic [1:0] res_mode;
  } psm_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/psm_cfg.sv =====
// Configuration register file of the mixer.
`default_nettype none

module psm_cfg
  import psm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output psm_cfg_t                   cfg_o
);

  psm_cfg_t cfg_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register writes, masked to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= PSM_CFG_RESET;
    end else if (cfg_valid_i) begin
      case (psm_reg_e'(cfg_index_i))
        REG_TONE_EN_L:  cfg_q.tone_en_l  <= cfg_data_i[3:0];
        REG_TONE_EN_R:  cfg_q.tone_en_r  <= cfg_data_i[3:0];
        REG_TONE_VOL_L: cfg_q.tone_vol_l <= cfg_data_i[2:0];
        REG_TONE_VOL_R: cfg_q.tone_vol_r <= cfg_data_i[2:0];
        REG_TONE_ATTEN: cfg_q.tone_atten <= psm_atten_e'(cfg_data_i[1:0]);
        REG_FIFO_ROUTE: cfg_q.fifo_route <= cfg_data_i[3:0];
        REG_BIAS:       cfg_q.bias       <= cfg_data_i[8:0];
        REG_RES_MODE:   cfg_q.res_mode   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/psm_mix.sv =====
// One side of the mixer: tone gain, attenuation, FIFO, bias, clamp, depth shift.
`default_nettype none

module psm_mix
  import psm_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] tone_i [4],
  input  wire logic signed [SAMPLE_W-1:0] fifo_a_i,
  input  wire logic signed [SAMPLE_W-1:0] fifo_b_i,
  input  wire psm_side_t                  side_i,
  output logic [LEVEL_W-1:0]              level_o
);

  logic        [3:0]          mul;
  logic        [SAMPLE_W-1:0] prod;
  logic        [SAMPLE_W-1:0] tone_sum;
  logic signed [SAMPLE_W-1:0] tone_att;
  logic        [SAMPLE_W-1:0] acc;
  logic        [CLAMP_W-1:0]  clamped;
  logic        [2:0]          shamt;

  // Tone sum, wrapping at 16 bits; gain is volume plus one
  always_comb begin
    mul      = {1'b0, side_i.tone_vol} + 4'd1;
    prod     = '0;
    tone_sum = '0;
    for (int i = 0; i < 4; i++) begin
      prod = 16'(tone_i[i] * 16'(mul));
      if (side_i.tone_en[i]) begin
        tone_sum = tone_sum + prod;
      end
    end
  end

  // Arithmetic attenuation of the tone sum
  always_comb begin
    case (side_i.atten)
      ATTEN_QUARTER: tone_att = $signed(tone_sum) >>> 2;
      ATTEN_HALF:    tone_att = $signed(tone_sum) >>> 1;
      default:       tone_att = $signed(tone_sum);
    endcase
  end

  // FIFO samples and bias, then clamp and depth reduction
  always_comb begin
    acc = tone_att;
    if (side_i.use_a) acc = acc + fifo_a_i;
    if (side_i.use_b) acc = acc + fifo_b_i;
    acc = acc + {7'b0, side_i.bias};

    if (acc[SAMPLE_W-1]) begin
      clamped = '0;
    end else if (acc > {6'b0, PSM_CLAMP_MAX}) begin
      clamped = PSM_CLAMP_MAX;
    end else begin
      clamped = acc[CLAMP_W-1:0];
    end

    shamt   = {1'b0, side_i.res_mode} + 3'd1;
    level_o = LEVEL_W'(clamped >> shamt);
  end

endmodule

`default_nettype wire

// ===== rtl/core/psm_dcblock.sv =====
// First-order DC-blocking filter for one side, with its capacitor register.
`default_nettype none

module psm_dcblock
  import psm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire logic [LEVEL_W-1:0]       level_i,
  input  wire logic [1:0]               res_mode_i,
  output logic signed [FILT_W-1:0]      filt_o
);

  logic signed [FILT_W-1:0] cap_q, cap_d;
  logic        [3:0]        shamt;
  logic        [17:0]       x_wide;
  logic        [15:0]       x;
  logic signed [21:0]       diff;
  logic signed [37:0]       prod;
  logic signed [21:0]       q;
  logic signed [21:0]       cap_raw;

  // Saturate to the signed 20-bit range
  function automatic logic signed [FILT_W-1:0] sat20(input logic signed [21:0] v);
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    hi = 22'sd524287;
    lo = -22'sd524288;
    if (v > hi) begin
      sat20 = 20'sd524287;
    end else if (v < lo) begin
      sat20 = -20'sd524288;
    end else begin
      sat20 = v[FILT_W-1:0];
    end
  endfunction

  // Normalize to Q.16, subtract the capacitor, then leak it toward the input
  always_comb begin
    shamt   = {2'b0, res_mode_i} + 4'd6;
    x_wide  = 18'(level_i) << shamt;
    x       = x_wide[15:0];
    diff    = $signed({6'b0, x}) - 22'(cap_q);
    filt_o  = sat20(diff);
    prod    = filt_o * $signed({1'b0, PSM_CAP_COEF});
    q       = prod[37:16];
    cap_raw = $signed({6'b0, x}) - q;
    cap_d   = sat20(cap_raw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (adv_i) begin
      cap_q <= cap_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psm_dma_sound_mixer.sv =====
// Stereo tone / direct-sound mixer with bias, clamp, depth shift and DC blocker.
//
// One sample request enters per clock while the input is not stalled, and
// its result passes an input register, a level register after the mixing
// logic, and the result register after the DC-blocking filter, whose
// 20 x 18 bit coefficient multiply sets the longest path. The filter
// capacitor of each side is updated as each request leaves the level
// register, so requests are filtered strictly in order. Empty stages keep
// filling while a finished result waits; the input stalls only when all
// three stages hold requests and the output is stalled. Configuration writes
// are accepted every cycle and should be made while the pipeline is empty.
`default_nettype none

module psg_dma_sound_mixer
  import psm_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data_i,
  // sample input
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0]   square_one_i,
  input  wire logic signed [SAMPLE_W-1:0]   square_two_i,
  input  wire logic signed [SAMPLE_W-1:0]   wave_sample_i,
  input  wire logic signed [SAMPLE_W-1:0]   noise_sample_i,
  input  wire logic signed [SAMPLE_W-1:0]   fifo_a_sample_i,
  input  wire logic signed [SAMPLE_W-1:0]   fifo_b_sample_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [LEVEL_W-1:0]                level_left_o,
  output logic [LEVEL_W-1:0]                level_right_o,
  output logic signed [FILT_W-1:0]          filtered_left_o,
  output logic signed [FILT_W-1:0]          filtered_right_o
);

  psm_cfg_t  cfg;
  psm_side_t side_l, side_r;

  logic                       a_valid_q, b_valid_q, out_valid_q;
  logic                       a_ready, b_ready, out_ready;
  logic                       b_adv;
  logic signed [SAMPLE_W-1:0] tone_q [4];
  logic signed [SAMPLE_W-1:0] fifo_a_q, fifo_b_q;
  logic [LEVEL_W-1:0]         mix_l, mix_r;
  logic [LEVEL_W-1:0]         lvl_l_q, lvl_r_q;
  logic signed [FILT_W-1:0]   filt_l, filt_r;
  logic [LEVEL_W-1:0]         out_lvl_l_q, out_lvl_r_q;
  logic signed [FILT_W-1:0]   out_filt_l_q, out_filt_r_q;

  psm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign b_ready    = !b_valid_q || out_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign b_adv      = b_valid_q && out_ready;
  assign in_stall_o = !a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready)   a_valid_q   <= in_valid_i;
      if (b_ready)   b_valid_q   <= a_valid_q;
      if (out_ready) out_valid_q <= b_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      tone_q[0] <= square_one_i;
      tone_q[1] <= square_two_i;
      tone_q[2] <= wave_sample_i;
      tone_q[3] <= noise_sample_i;
      fifo_a_q  <= fifo_a_sample_i;
      fifo_b_q  <= fifo_b_sample_i;
    end
  end

  // Per-side controls
  assign side_l = '{
    tone_en:  cfg.tone_en_l,
    tone_vol: cfg.tone_vol_l,
    use_a:    cfg.fifo_route[0],
    use_b:    cfg.fifo_route[2],
    atten:    cfg.tone_atten,
    bias:     cfg.bias,
    res_mode: cfg.res_mode
  };
  assign side_r = '{
    tone_en:  cfg.tone_en_r,
    tone_vol: cfg.tone_vol_r,
    use_a:    cfg.fifo_route[1],
    use_b:    cfg.fifo_route[3],
    atten:    cfg.tone_atten,
    bias:     cfg.bias,
    res_mode: cfg.res_mode
  };

  psm_mix u_mix_l (
    .tone_i   (tone_q),
    .fifo_a_i (fifo_a_q),
    .fifo_b_i (fifo_b_q),
    .side_i   (side_l),
    .level_o  (mix_l)
  );

  psm_mix u_mix_r (
    .tone_i   (tone_q),
    .fifo_a_i (fifo_a_q),
    .fifo_b_i (fifo_b_q),
    .side_i   (side_r),
    .level_o  (mix_r)
  );

  // Level register
  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      lvl_l_q <= mix_l;
      lvl_r_q <= mix_r;
    end
  end

  psm_dcblock u_dc_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (b_adv),
    .level_i    (lvl_l_q),
    .res_mode_i (cfg.res_mode),
    .filt_o     (filt_l)
  );

  psm_dcblock u_dc_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (b_adv),
    .level_i    (lvl_r_q),
    .res_mode_i (cfg.res_mode),
    .filt_o     (filt_r)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_lvl_l_q  <= lvl_l_q;
      out_lvl_r_q  <= lvl_r_q;
      out_filt_l_q <= filt_l;
      out_filt_r_q <= filt_r;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign level_left_o     = out_lvl_l_q;
  assign level_right_o    = out_lvl_r_q;
  assign filtered_left_o  = out_filt_l_q;
  assign filtered_right_o = out_filt_r_q;

`ifndef NO_ASSERTIONS
  // Input stalls only with every stage full and the output held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_valid_q && b_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A request leaving the level stage shows up at the output unchanged
  a_level_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> (out_valid_o && level_left_o == $past(lvl_l_q)
               && level_right_o == $past(lvl_r_q)))
    else $error("level stage not forwarded to result register");

  // Output level never exceeds the clamp ceiling after the depth shift
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, level_left_o} <= (PSM_CLAMP_MAX >> ({1'b0, cfg.res_mode} + 3'd1))
                     && {1'b0, level_right_o}
                        <= (PSM_CLAMP_MAX >> ({1'b0, cfg.res_mode} + 3'd1))))
    else $error("output level out of range");

  // A held result stays visible when the output is stalled
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && !b_adv) || out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire
